// ===== rtl/awsu_pkg.sv =====
// Shared types and constants of the arbitrary waveform sequencer.
// Used by the controller, the datapath and the top level; depends on nothing.
package awsu_pkg;

    // Field widths fixed by the interface.
    localparam int TIME_W  = 15;
    localparam int VALUE_W = 28;
    localparam int CFG_W   = 15;

    // Interpolation arithmetic widths.
    localparam int DIFF_W     = 18;  // signed time differences
    localparam int DV_W       = 29;  // signed value difference
    localparam int PROD_W     = 47;  // signed product
    localparam int DMAG_W     = 17;  // divisor magnitude
    localparam int REM_W      = 18;  // partial remainder
    localparam int SUM_W      = 49;  // final signed sum
    localparam int DIV_STEPS  = 47;
    localparam int DIV_CNT_W  = 6;
    localparam int ENTRY_W    = TIME_W + VALUE_W + 1;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    // Reset values of the configuration registers.
    localparam logic [TIME_W-1:0] LEN_RESET = 15'd1000;
    localparam logic [5:0]        PC_RESET  = 6'd1;

    // Function codes.
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_WRITE  = 2'd1;
    localparam logic [1:0] FUNC_SETRUN = 2'd2;

    // Run states.
    localparam logic [1:0] RS_DISABLED = 2'd0;
    localparam logic [1:0] RS_ARMED    = 2'd1;
    localparam logic [1:0] RS_RUNNING  = 2'd2;
    localparam logic [1:0] RS_INVALID  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_REPEAT = 2'd0;
    localparam logic [1:0] REG_LENGTH = 2'd1;
    localparam logic [1:0] REG_COUNT  = 2'd2;
    localparam logic [1:0] REG_TARGET = 2'd3;

    // Which pair of points bounds the segment.
    typedef enum logic [1:0] {
        SEG_MID,
        SEG_WRAP_LO,
        SEG_WRAP_HI
    } seg_mode_t;

    typedef struct packed {
        logic      latch;
        logic      write;
        logic      store_left;
        logic      store_first;
        logic      store_right;
        logic      setup;
        seg_mode_t mode;
        logic      res_left;
        logic      mul;
        logic      div_load;
        logic      div_step;
        logic      finish;
    } dp_cmd_t;

    typedef struct packed {
        logic t_below;
        logic lerp_needed;
    } dp_stat_t;

    typedef struct packed {
        logic       done;
        logic       sp_valid;
        logic [1:0] run_state;
        logic       power_off;
        logic [1:0] target;
    } ctrl_res_t;

endpackage

// ===== rtl/awsu_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// Stand-alone; no package needed.
module awsu_ram #(
    parameter int WIDTH = 44,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/awsu_dp.sv =====
// Datapath: point table, segment setup, multiplier and serial divider.
// Depends on awsu_pkg and awsu_ram; driven by awsu_ctrl commands.
module awsu_dp #(
    parameter int MAX_POINTS = 32,
    localparam int IDX_W = $clog2(MAX_POINTS)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  awsu_pkg::dp_cmd_t            cmd,
    output awsu_pkg::dp_stat_t           stat,
    input  logic [IDX_W-1:0]             rd_addr,
    input  logic [awsu_pkg::TIME_W-1:0]  ticks,
    input  logic [awsu_pkg::TIME_W-1:0]  seq_len,
    input  logic [4:0]                   s_point_index,
    input  logic [awsu_pkg::TIME_W-1:0]  s_point_time,
    input  logic [awsu_pkg::VALUE_W-1:0] s_point_value,
    input  logic                         s_point_hold,
    output logic [awsu_pkg::VALUE_W-1:0] result
);

    localparam int TW = awsu_pkg::TIME_W;
    localparam int VW = awsu_pkg::VALUE_W;

    // Latched point word.
    logic [4:0]    pi_reg;
    logic [TW-1:0] pt_reg;
    logic [VW-1:0] pv_reg;
    logic          ph_reg;

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            pi_reg <= s_point_index;
            pt_reg <= s_point_time;
            pv_reg <= s_point_value;
            ph_reg <= s_point_hold;
        end
    end

    // Point table; entry zero reads as zero until first written.
    logic [awsu_pkg::ENTRY_W-1:0] ram_rdata;
    logic [awsu_pkg::ENTRY_W-1:0] entry;
    logic [IDX_W-1:0]             rd_addr_reg;
    logic                         ent0_ok_reg;

    awsu_ram #(
        .WIDTH (awsu_pkg::ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.write),
        .waddr (IDX_W'(pi_reg)),
        .wdata ({pt_reg, pv_reg, ph_reg}),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        rd_addr_reg <= rd_addr;
        if (!aresetn) begin
            ent0_ok_reg <= 1'b0;
        end else if (cmd.write && pi_reg == 5'd0) begin
            ent0_ok_reg <= 1'b1;
        end
    end

    assign entry = (rd_addr_reg == '0 && !ent0_ok_reg) ? '0 : ram_rdata;

    logic [TW-1:0] e_time;
    logic [VW-1:0] e_value;
    logic          e_hold;
    assign {e_time, e_value, e_hold} = entry;

    assign stat.t_below = ticks < e_time;

    // Segment end points.
    logic [TW-1:0] left_t_reg, right_t_reg, first_t_reg;
    logic [VW-1:0] left_v_reg, right_v_reg, first_v_reg;
    logic          left_h_reg;

    always_ff @(posedge aclk) begin
        if (cmd.store_left) begin
            left_t_reg <= e_time;
            left_v_reg <= e_value;
            left_h_reg <= e_hold;
        end
        if (cmd.store_first) begin
            first_t_reg <= e_time;
            first_v_reg <= e_value;
        end
        if (cmd.store_right) begin
            right_t_reg <= e_time;
            right_v_reg <= e_value;
        end
    end

    // Segment setup: offsets, span and value step.
    logic signed [awsu_pkg::DIFF_W-1:0] t_s, tl_s, tr_s, len_s;
    logic [VW-1:0]                      vr;
    logic signed [awsu_pkg::DIFF_W-1:0] diff_reg, den_reg;
    logic signed [awsu_pkg::DV_W-1:0]   dv_reg;

    always_comb begin
        t_s   = {3'b000, ticks};
        len_s = {3'b000, seq_len};
        tl_s  = {3'b000, left_t_reg};
        tr_s  = {3'b000, right_t_reg};
        vr    = right_v_reg;
        if (cmd.mode == awsu_pkg::SEG_WRAP_LO) begin
            tl_s = {3'b000, left_t_reg} - len_s;
        end
        if (cmd.mode == awsu_pkg::SEG_WRAP_HI) begin
            tr_s = len_s + {3'b000, first_t_reg};
            vr   = first_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            diff_reg <= t_s - tl_s;
            den_reg  <= tr_s - tl_s;
            dv_reg   <= $signed({1'b0, vr}) - $signed({1'b0, left_v_reg});
        end
    end

    assign stat.lerp_needed = left_h_reg && (den_reg != '0);

    // Multiply, then divide one quotient bit per cycle.
    logic signed [awsu_pkg::PROD_W-1:0] prod_reg;
    logic [awsu_pkg::PROD_W-1:0]        quo_reg;
    logic [awsu_pkg::DMAG_W-1:0]        dmag_reg;
    logic [awsu_pkg::REM_W-1:0]         rem_reg;
    logic                               neg_reg;
    logic [awsu_pkg::REM_W-1:0]         rem_sh;
    logic                               ge;
    logic [awsu_pkg::DIFF_W-1:0]        den_abs;

    assign rem_sh  = {rem_reg[awsu_pkg::REM_W-2:0], quo_reg[awsu_pkg::PROD_W-1]};
    assign ge      = rem_sh >= {1'b0, dmag_reg};
    assign den_abs = den_reg[awsu_pkg::DIFF_W-1] ? -den_reg : den_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= awsu_pkg::PROD_W'(diff_reg) * awsu_pkg::PROD_W'(dv_reg);
        end
        if (cmd.div_load) begin
            quo_reg  <= prod_reg[awsu_pkg::PROD_W-1] ? -prod_reg : prod_reg;
            dmag_reg <= den_abs[awsu_pkg::DMAG_W-1:0];
            neg_reg  <= prod_reg[awsu_pkg::PROD_W-1] ^ den_reg[awsu_pkg::DIFF_W-1];
            rem_reg  <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= ge ? (rem_sh - {1'b0, dmag_reg}) : rem_sh;
            quo_reg <= {quo_reg[awsu_pkg::PROD_W-2:0], ge};
        end
    end

    // Final sum with saturation.
    logic signed [awsu_pkg::SUM_W-1:0] q_s, sum_s;

    always_comb begin
        q_s   = neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});
        sum_s = q_s + $signed({21'd0, left_v_reg});
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_left) begin
            result <= left_v_reg;
        end else if (cmd.finish) begin
            if (sum_s < 0) begin
                result <= '0;
            end else if (sum_s > $signed({21'd0, awsu_pkg::VALUE_MAX})) begin
                result <= awsu_pkg::VALUE_MAX;
            end else begin
                result <= sum_s[VW-1:0];
            end
        end
    end

endmodule

// ===== rtl/awsu_ctrl.sv =====
// Controller: configuration registers, run state, tick timing and table walk.
// Depends on awsu_pkg; commands awsu_dp.
module awsu_ctrl #(
    parameter int MAX_POINTS = 32,
    localparam int IDX_W = $clog2(MAX_POINTS),
    localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_func,
    input  logic                         s_power_on,
    input  logic [4:0]                   s_point_index,
    input  logic [1:0]                   s_new_run_state,
    input  logic                         cfg_valid,
    input  logic [1:0]                   cfg_index,
    input  logic [awsu_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         out_free,
    output awsu_pkg::dp_cmd_t            cmd,
    input  awsu_pkg::dp_stat_t           stat,
    output logic [IDX_W-1:0]             rd_addr,
    output logic [awsu_pkg::TIME_W-1:0]  ticks,
    output logic [awsu_pkg::TIME_W-1:0]  seq_len,
    output awsu_pkg::ctrl_res_t          res
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_WRITE, ST_READ, ST_CMP, ST_SETUP, ST_DECIDE,
        ST_MUL, ST_DIVLD, ST_DIV, ST_FIN, ST_OUT
    } state_t;

    state_t                          state_reg;
    logic                            repeat_reg;
    logic [awsu_pkg::TIME_W-1:0]     len_reg;
    logic [5:0]                      count_reg;
    logic [1:0]                      target_reg;
    logic [1:0]                      rs_reg;
    logic [awsu_pkg::TIME_W-1:0]     el_reg;
    logic                            poff_reg;
    logic                            spv_reg;
    logic [CNT_W-1:0]                idx_reg;
    logic                            last_rd_reg;
    awsu_pkg::seg_mode_t             mode_reg;
    logic [awsu_pkg::DIV_CNT_W-1:0]  div_cnt_reg;

    logic accept;
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Effective point count, clamped to one .. MAX_POINTS.
    logic [8:0]       n9;
    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] idx_inc;

    always_comb begin
        if (count_reg == 6'd0) begin
            n9 = 9'd1;
        end else if ({3'b000, count_reg} > 9'(MAX_POINTS)) begin
            n9 = 9'(MAX_POINTS);
        end else begin
            n9 = {3'b000, count_reg};
        end
        n_eff   = CNT_W'(n9);
        idx_inc = idx_reg + 1'b1;
    end

    // Tick update of run state and elapsed time.
    logic [1:0]                  tick_rs;
    logic [awsu_pkg::TIME_W:0]   tick_el;
    logic                        tick_poff;

    always_comb begin
        tick_rs   = rs_reg;
        tick_el   = {1'b0, el_reg};
        tick_poff = 1'b0;
        if (rs_reg == awsu_pkg::RS_ARMED && s_power_on) begin
            tick_rs = awsu_pkg::RS_RUNNING;
            tick_el = '0;
        end
        if (tick_rs == awsu_pkg::RS_RUNNING) begin
            tick_el = tick_el + 1'b1;
            if (tick_el > {1'b0, len_reg}) begin
                tick_el = '0;
                if (!repeat_reg) begin
                    tick_rs   = awsu_pkg::RS_ARMED;
                    tick_poff = 1'b1;
                end
            end
        end
    end

    // Command decode.
    always_comb begin
        cmd             = '0;
        cmd.mode        = mode_reg;
        cmd.latch       = accept;
        cmd.write       = (state_reg == ST_WRITE);
        cmd.setup       = (state_reg == ST_SETUP);
        cmd.mul         = (state_reg == ST_MUL);
        cmd.div_load    = (state_reg == ST_DIVLD);
        cmd.div_step    = (state_reg == ST_DIV);
        cmd.finish      = (state_reg == ST_FIN);
        cmd.res_left    = (state_reg == ST_DECIDE) && !stat.lerp_needed;
        if (state_reg == ST_CMP) begin
            if (last_rd_reg) begin
                cmd.store_left = 1'b1;
            end else if (stat.t_below) begin
                cmd.store_right = 1'b1;
            end else begin
                cmd.store_left  = 1'b1;
                cmd.store_first = (idx_reg == '0);
            end
        end
    end

    assign rd_addr = idx_reg[IDX_W-1:0];
    assign ticks   = el_reg;
    assign seq_len = len_reg;

    assign res.done      = (state_reg == ST_OUT) && out_free;
    assign res.sp_valid  = spv_reg;
    assign res.run_state = rs_reg;
    assign res.power_off = poff_reg;
    assign res.target    = target_reg;

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            repeat_reg  <= 1'b1;
            len_reg     <= awsu_pkg::LEN_RESET;
            count_reg   <= awsu_pkg::PC_RESET;
            target_reg  <= '0;
            rs_reg      <= awsu_pkg::RS_DISABLED;
            el_reg      <= '0;
            poff_reg    <= 1'b0;
            spv_reg     <= 1'b0;
            idx_reg     <= '0;
            last_rd_reg <= 1'b0;
            mode_reg    <= awsu_pkg::SEG_MID;
            div_cnt_reg <= '0;
        end else begin
            // Configuration writes.
            if (cfg_valid) begin
                case (cfg_index)
                    awsu_pkg::REG_REPEAT: repeat_reg <= cfg_data[0];
                    awsu_pkg::REG_LENGTH: len_reg    <= cfg_data;
                    awsu_pkg::REG_COUNT:  count_reg  <= cfg_data[5:0];
                    awsu_pkg::REG_TARGET: target_reg <= cfg_data[1:0];
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        poff_reg    <= 1'b0;
                        spv_reg     <= 1'b0;
                        idx_reg     <= '0;
                        last_rd_reg <= 1'b0;
                        state_reg   <= ST_OUT;
                        case (s_func)
                            awsu_pkg::FUNC_TICK: begin
                                rs_reg   <= tick_rs;
                                el_reg   <= tick_el[awsu_pkg::TIME_W-1:0];
                                poff_reg <= tick_poff;
                                if (tick_rs == awsu_pkg::RS_RUNNING) begin
                                    spv_reg   <= 1'b1;
                                    state_reg <= ST_READ;
                                end
                            end
                            awsu_pkg::FUNC_WRITE: begin
                                if (9'(s_point_index) < 9'(MAX_POINTS)) begin
                                    state_reg <= ST_WRITE;
                                end
                            end
                            awsu_pkg::FUNC_SETRUN: begin
                                if (s_new_run_state != awsu_pkg::RS_INVALID) begin
                                    rs_reg   <= s_new_run_state;
                                    poff_reg <= (s_new_run_state != awsu_pkg::RS_RUNNING);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_WRITE: begin
                    state_reg <= ST_OUT;
                end
                ST_READ: begin
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    if (last_rd_reg) begin
                        state_reg <= ST_SETUP;
                    end else if (stat.t_below) begin
                        if (idx_reg == '0) begin
                            // Before the first point: fetch the last one.
                            idx_reg     <= n_eff - 1'b1;
                            last_rd_reg <= 1'b1;
                            mode_reg    <= awsu_pkg::SEG_WRAP_LO;
                            state_reg   <= ST_READ;
                        end else begin
                            mode_reg  <= awsu_pkg::SEG_MID;
                            state_reg <= ST_SETUP;
                        end
                    end else if (idx_inc == n_eff) begin
                        // Past the last point: wrap to the first.
                        mode_reg  <= awsu_pkg::SEG_WRAP_HI;
                        state_reg <= ST_SETUP;
                    end else begin
                        idx_reg   <= idx_inc;
                        state_reg <= ST_READ;
                    end
                end
                ST_SETUP: begin
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    state_reg <= stat.lerp_needed ? ST_MUL : ST_OUT;
                end
                ST_MUL: begin
                    state_reg <= ST_DIVLD;
                end
                ST_DIVLD: begin
                    div_cnt_reg <= '0;
                    state_reg   <= ST_DIV;
                end
                ST_DIV: begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == awsu_pkg::DIV_CNT_W'(awsu_pkg::DIV_STEPS - 1)) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/arbitrary_waveform_sequencer_unit.sv =====
// Top level of the arbitrary waveform sequencer: controller, datapath and
// output register. Depends on awsu_pkg, awsu_ctrl and awsu_dp.
//
// Usage: each word on the s_ channel is a tick, a point write, a run-state
// change or a no-operation; each gives exactly one result word on the m_
// channel. Registers are written on the cfg_ channel (always ready); the user
// must write them only while the block is idle, a rule the block leaves
// unchecked. A point write passes through a write state to the output
// register; a run-state change or an idle tick goes straight there. A running
// tick walks the point table entry by entry (registered table read, then
// compare); a linear segment adds a multiply, a divider load, a restoring
// divider and a final sum. One word is processed at a time; the next is
// accepted as soon as the previous result sits in the output register.
// Reset (aresetn, synchronous, active low) disables the sequence, clears the
// elapsed time and restores the register defaults; table entry 0 reads as
// zero until written. If the receiver stalls, the result holds in the output
// register and the block stops accepting words once its next result is ready.
module arbitrary_waveform_sequencer_unit #(
    parameter int MAX_POINTS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_func,
    input  logic                         s_power_on,
    input  logic [4:0]                   s_point_index,
    input  logic [14:0]                  s_point_time,
    input  logic [27:0]                  s_point_value,
    input  logic                         s_point_hold,
    input  logic [1:0]                   s_new_run_state,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [27:0]                  m_setpoint,
    output logic                         m_setpoint_valid,
    output logic [1:0]                   m_target,
    output logic [1:0]                   m_run_state_out,
    output logic                         m_power_off,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [14:0]                  cfg_data
);

    localparam int IDX_W = $clog2(MAX_POINTS);

    awsu_pkg::dp_cmd_t           cmd;
    awsu_pkg::dp_stat_t          stat;
    awsu_pkg::ctrl_res_t         res;
    logic [IDX_W-1:0]            rd_addr;
    logic [awsu_pkg::TIME_W-1:0] ticks;
    logic [awsu_pkg::TIME_W-1:0] seq_len;
    logic [awsu_pkg::VALUE_W-1:0] result;
    logic                        out_free;

    assign cfg_ready = 1'b1;

    awsu_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_power_on      (s_power_on),
        .s_point_index   (s_point_index),
        .s_new_run_state (s_new_run_state),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_free        (out_free),
        .cmd             (cmd),
        .stat            (stat),
        .rd_addr         (rd_addr),
        .ticks           (ticks),
        .seq_len         (seq_len),
        .res             (res)
    );

    awsu_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .rd_addr       (rd_addr),
        .ticks         (ticks),
        .seq_len       (seq_len),
        .s_point_index (s_point_index),
        .s_point_time  (s_point_time),
        .s_point_value (s_point_value),
        .s_point_hold  (s_point_hold),
        .result        (result)
    );

    // Output register: loaded when a result is done, freed when taken.
    assign out_free = !m_valid || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (res.done) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.done) begin
            m_setpoint       <= res.sp_valid ? result : '0;
            m_setpoint_valid <= res.sp_valid;
            m_target         <= res.target;
            m_run_state_out  <= res.run_state;
            m_power_off      <= res.power_off;
        end
    end

endmodule

// ===== verif/awsu_scoreboard.sv =====
`timescale 1ns / 100ps
// Scoreboard for the arbitrary waveform sequencer: watches the s_, m_ and cfg_ channels,
// predicts each result word and compares it. Depends on awsu_pkg only.
module awsu_scoreboard (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic        s_power_on,
    input  logic [4:0]  s_point_index,
    input  logic [14:0] s_point_time,
    input  logic [27:0] s_point_value,
    input  logic        s_point_hold,
    input  logic [1:0]  s_new_run_state,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [27:0] m_setpoint,
    input  logic        m_setpoint_valid,
    input  logic [1:0]  m_target,
    input  logic [1:0]  m_run_state_out,
    input  logic        m_power_off,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data,
    output int          n_pending,
    output int          n_fail
);

    localparam int TABLE_DEPTH = 32;

    typedef struct packed {
        logic [27:0] setpoint;
        logic        sp_valid;
        logic [1:0]  target;
        logic [1:0]  run_state;
        logic        power_off;
    } result_word_t;

    // Mirror of the block's registers and state.
    logic              repeat_on;
    logic [14:0]       seq_len;
    logic [5:0]        pt_count;
    logic [1:0]        target_sel;
    logic [1:0]        run_st;
    int                elapsed;
    logic [14:0]       pt_time [TABLE_DEPTH];
    logic [27:0]       pt_value [TABLE_DEPTH];
    logic              pt_hold [TABLE_DEPTH];

    result_word_t      results_due[$];

    // Linear interpolation with truncating division, saturated to the value range.
    function automatic logic [27:0] interpolate(longint t, longint tl, longint tr,
                                                longint vl, longint vr);
        longint r;
        if (tr == tl) return vl[27:0];
        r = vl + ((t - tl) * (vr - vl)) / (tr - tl);
        if (r < 0) r = 0;
        if (r > longint'(awsu_pkg::VALUE_MAX)) r = longint'(awsu_pkg::VALUE_MAX);
        return r[27:0];
    endfunction

    // Waveform value at time t, wrapping across the ends of the table.
    function automatic logic [27:0] waveform_at(int t);
        int n;
        int i;
        int last;
        longint len;
        n = pt_count;
        len = seq_len;
        if (n == 0) n = 1;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        last = n - 1;
        i = 0;
        while (i < n && !(t < pt_time[i])) i++;
        if (i > 0 && i < n) begin
            if (!pt_hold[i-1]) return pt_value[i-1];
            return interpolate(t, pt_time[i-1], pt_time[i], pt_value[i-1], pt_value[i]);
        end
        if (!pt_hold[last]) return pt_value[last];
        if (i == 0)
            return interpolate(t, longint'(pt_time[last]) - len, pt_time[0],
                               pt_value[last], pt_value[0]);
        return interpolate(t, pt_time[last], len + longint'(pt_time[0]),
                           pt_value[last], pt_value[0]);
    endfunction

    // Applies one accepted word to the mirrored state and returns its result.
    function automatic result_word_t predict_word();
        result_word_t w;
        w = '0;
        case (s_func)
            awsu_pkg::FUNC_TICK: begin
                if (run_st == awsu_pkg::RS_ARMED && s_power_on) begin
                    elapsed = 0;
                    run_st = awsu_pkg::RS_RUNNING;
                end
                if (run_st == awsu_pkg::RS_RUNNING) begin
                    elapsed++;
                    if (elapsed > seq_len) begin
                        elapsed = 0;
                        if (!repeat_on) begin
                            run_st = awsu_pkg::RS_ARMED;
                            w.power_off = 1'b1;
                        end
                    end
                end
                elapsed = elapsed & 32'h7FFF;
                if (run_st == awsu_pkg::RS_RUNNING) begin
                    w.setpoint = waveform_at(elapsed);
                    w.sp_valid = 1'b1;
                end
            end
            awsu_pkg::FUNC_WRITE: begin
                pt_time[s_point_index]  = s_point_time;
                pt_value[s_point_index] = s_point_value;
                pt_hold[s_point_index]  = s_point_hold;
            end
            awsu_pkg::FUNC_SETRUN: begin
                if (s_new_run_state != awsu_pkg::RS_INVALID) begin
                    run_st = s_new_run_state;
                    if (s_new_run_state != awsu_pkg::RS_RUNNING) w.power_off = 1'b1;
                end
            end
            default: ;
        endcase
        w.target = target_sel;
        w.run_state = run_st;
        return w;
    endfunction

    always @(posedge aclk) begin
        result_word_t want;
        int errs;
        errs = 0;
        if (!aresetn) begin
            repeat_on  <= 1'b1;
            seq_len    <= awsu_pkg::LEN_RESET;
            pt_count   <= awsu_pkg::PC_RESET;
            target_sel <= '0;
            run_st     = awsu_pkg::RS_DISABLED;
            elapsed    = 0;
            pt_time[0]  = '0;
            pt_value[0] = '0;
            pt_hold[0]  = 1'b0;
            results_due.delete();
            n_pending  <= 0;
            n_fail     <= 0;
        end else begin
            // Register writes.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    awsu_pkg::REG_REPEAT: repeat_on  <= cfg_data[0];
                    awsu_pkg::REG_LENGTH: seq_len    <= cfg_data;
                    awsu_pkg::REG_COUNT:  pt_count   <= cfg_data[5:0];
                    awsu_pkg::REG_TARGET: target_sel <= cfg_data[1:0];
                    default: ;
                endcase
            end
            // Result words against the oldest prediction.
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $error("result word with no prediction waiting");
                    errs++;
                end else begin
                    want = results_due.pop_front();
                    if (m_setpoint !== want.setpoint) begin
                        $error("setpoint: expected %0d, got %0d", want.setpoint, m_setpoint);
                        errs++;
                    end
                    if (m_setpoint_valid !== want.sp_valid) begin
                        $error("setpoint_valid: expected %0d, got %0d",
                               want.sp_valid, m_setpoint_valid);
                        errs++;
                    end
                    if (m_target !== want.target) begin
                        $error("target: expected %0d, got %0d", want.target, m_target);
                        errs++;
                    end
                    if (m_run_state_out !== want.run_state) begin
                        $error("run_state_out: expected %0d, got %0d",
                               want.run_state, m_run_state_out);
                        errs++;
                    end
                    if (m_power_off !== want.power_off) begin
                        $error("power_off: expected %0d, got %0d", want.power_off, m_power_off);
                        errs++;
                    end
                end
            end
            // Input words.
            if (s_valid && s_ready) results_due.push_back(predict_word());
            n_pending <= results_due.size();
            n_fail    <= n_fail + errs;
        end
    end

endmodule

// ===== verif/tb_arbitrary_waveform_sequencer_unit.sv =====
`timescale 1ns / 100ps
// Testbench top for the arbitrary waveform sequencer: clock, reset, stimulus and verdict.
// Depends on awsu_pkg, the block itself and awsu_scoreboard.
module tb_arbitrary_waveform_sequencer_unit;

    localparam logic [1:0] FUNC_IDLE = 2'd3;   // no operation, reports state
    localparam int IDLE_LIMIT  = 20000;
    localparam int HOLD_CYCLES = 500;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 120;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = '0;
    logic        s_power_on = 1'b0;
    logic [4:0]  s_point_index = '0;
    logic [14:0] s_point_time = '0;
    logic [27:0] s_point_value = '0;
    logic        s_point_hold = 1'b0;
    logic [1:0]  s_new_run_state = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [27:0] m_setpoint;
    logic        m_setpoint_valid;
    logic [1:0]  m_target;
    logic [1:0]  m_run_state_out;
    logic        m_power_off;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [14:0] cfg_data = '0;

    int          n_pending;
    int          n_fail;
    logic        no_gaps = 1'b0;
    logic [31:0] written = 32'h1;  // entry 0 is defined from reset
    logic [14:0] cur_len = awsu_pkg::LEN_RESET;

    arbitrary_waveform_sequencer_unit dut (.*);

    awsu_scoreboard scoreboard (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Count of leading table entries that hold written points.
    function automatic int written_prefix();
        int n;
        n = 0;
        while (n < 32 && written[n]) n++;
        return n;
    endfunction

    // Offers one word on the s_ channel and waits for it to be taken.
    task automatic send_word(logic [1:0] f, logic pwr, logic [4:0] idx, logic [14:0] tm,
                             logic [27:0] val, logic hold, logic [1:0] rs);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_func          <= f;
        s_power_on      <= pwr;
        s_point_index   <= idx;
        s_point_time    <= tm;
        s_point_value   <= val;
        s_point_hold    <= hold;
        s_new_run_state <= rs;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (f == awsu_pkg::FUNC_WRITE) written[idx] = 1'b1;
    endtask

    // Writes one register; the caller lowers cfg_valid after its last write.
    task automatic write_reg(logic [1:0] idx, logic [14:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == awsu_pkg::REG_LENGTH) cur_len = data;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
    endtask

    // One random word, weighted towards ticks on a running sequence.
    task automatic send_random_word();
        int r;
        int idx;
        logic [14:0] tm;
        logic [27:0] val;
        logic [1:0] rs;
        r = $urandom_range(0, 99);
        idx = ($urandom_range(0, 1) == 0) ? written_prefix() % 32 : $urandom_range(0, 31);
        if ($urandom_range(0, 6) == 0) tm = 15'($urandom);
        else tm = 15'((idx * cur_len) / 32 + $urandom_range(0, cur_len / 64));
        val = ($urandom_range(0, 4) == 0) ? 28'($urandom)
                                          : 28'($urandom_range(0, 200000000));
        r = $urandom_range(0, 99);
        if (r < 50) rs = awsu_pkg::RS_RUNNING;
        else if (r < 75) rs = awsu_pkg::RS_ARMED;
        else if (r < 90) rs = awsu_pkg::RS_DISABLED;
        else rs = awsu_pkg::RS_INVALID;
        r = $urandom_range(0, 99);
        send_word((r < 65) ? awsu_pkg::FUNC_TICK : (r < 85) ? awsu_pkg::FUNC_WRITE
                  : (r < 97) ? awsu_pkg::FUNC_SETRUN : FUNC_IDLE,
                  ($urandom_range(0, 99) < 85), idx[4:0], tm, val,
                  1'($urandom_range(0, 1)), rs);
    endtask

    // Result side: random stalls, plus one long hold-off while words keep coming.
    int results_seen = 0;
    int stall_left = 0;
    int hold_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (results_seen == 400) hold_left <= HOLD_CYCLES;
                else if (!no_gaps && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
            end
        end
    end

    // Watchdog on cycles with no handshake at all.
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int n_ok;
        int cnt;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: run-state handling and table extremes with reset registers.
        send_word(awsu_pkg::FUNC_TICK, 1'b0, 5'd0, 15'd0, 28'd0, 1'b0, awsu_pkg::RS_DISABLED);
        send_word(FUNC_IDLE, 1'b1, 5'd0, 15'd0, 28'd0, 1'b0, awsu_pkg::RS_DISABLED);
        send_word(awsu_pkg::FUNC_SETRUN, 1'b0, 5'd0, 15'd0, 28'd0, 1'b0, awsu_pkg::RS_INVALID);
        send_word(awsu_pkg::FUNC_SETRUN, 1'b0, 5'd0, 15'd0, 28'd0, 1'b0, awsu_pkg::RS_ARMED);
        send_word(awsu_pkg::FUNC_TICK, 1'b0, 5'd0, 15'd0, 28'd0, 1'b0, awsu_pkg::RS_DISABLED);
        send_word(awsu_pkg::FUNC_TICK, 1'b1, 5'd0, 15'd0, 28'd0, 1'b0, awsu_pkg::RS_DISABLED);
        send_word(awsu_pkg::FUNC_WRITE, 1'b0, 5'd0, 15'd0, awsu_pkg::VALUE_MAX, 1'b1,
                  awsu_pkg::RS_DISABLED);
        send_word(awsu_pkg::FUNC_WRITE, 1'b0, 5'd31, 15'h7FFF, 28'd0, 1'b0,
                  awsu_pkg::RS_DISABLED);
        send_word(awsu_pkg::FUNC_TICK, 1'b1, 5'd0, 15'd0, 28'd0, 1'b0, awsu_pkg::RS_DISABLED);
        send_word(awsu_pkg::FUNC_WRITE, 1'b0, 5'd1, 15'd1, 28'd0, 1'b1, awsu_pkg::RS_DISABLED);
        send_word(awsu_pkg::FUNC_SETRUN, 1'b0, 5'd0, 15'd0, 28'd0, 1'b0, awsu_pkg::RS_DISABLED);
        send_word(awsu_pkg::FUNC_SETRUN, 1'b0, 5'd0, 15'd0, 28'd0, 1'b0, awsu_pkg::RS_RUNNING);
        send_word(awsu_pkg::FUNC_TICK, 1'b0, 5'd0, 15'd0, 28'd0, 1'b0, awsu_pkg::RS_DISABLED);
        wait_drained();

        // Directed: short single-shot sequence, wrap and rearm, point count zero.
        write_reg(awsu_pkg::REG_REPEAT, 15'd0);
        write_reg(awsu_pkg::REG_LENGTH, 15'd2);
        write_reg(awsu_pkg::REG_COUNT, 15'd0);
        write_reg(awsu_pkg::REG_TARGET, 15'd3);
        cfg_valid <= 1'b0;
        send_word(awsu_pkg::FUNC_SETRUN, 1'b0, 5'd0, 15'd0, 28'd0, 1'b0, awsu_pkg::RS_ARMED);
        repeat (4) send_word(awsu_pkg::FUNC_TICK, 1'b1, 5'd0, 15'd0, 28'd0, 1'b0,
                             awsu_pkg::RS_DISABLED);
        send_word(awsu_pkg::FUNC_TICK, 1'b0, 5'd0, 15'd0, 28'd0, 1'b0, awsu_pkg::RS_DISABLED);
        send_word(awsu_pkg::FUNC_TICK, 1'b1, 5'd0, 15'd0, 28'd0, 1'b0, awsu_pkg::RS_DISABLED);
        wait_drained();

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < PHASES; ph++) begin
            n_ok = written_prefix();
            if (n_ok == 32 && $urandom_range(0, 2) == 0) cnt = $urandom_range(33, 63);
            else if ($urandom_range(0, 2) == 0) cnt = $urandom_range(0, n_ok);
            else cnt = n_ok;
            write_reg(awsu_pkg::REG_REPEAT, 15'(ph % 2));
            case (ph % 5)
                0: write_reg(awsu_pkg::REG_LENGTH, 15'd2);
                1: write_reg(awsu_pkg::REG_LENGTH, 15'($urandom_range(3, 40)));
                2: write_reg(awsu_pkg::REG_LENGTH, 15'd30000);
                3: write_reg(awsu_pkg::REG_LENGTH, 15'h7FFF);
                default: write_reg(awsu_pkg::REG_LENGTH, 15'($urandom_range(41, 400)));
            endcase
            write_reg(awsu_pkg::REG_COUNT, 15'(cnt));
            write_reg(awsu_pkg::REG_TARGET, 15'(ph % 4));
            cfg_valid <= 1'b0;
            no_gaps = (ph % 3 == 1);
            for (int k = 0; k < PHASE_WORDS; k++) send_random_word();
            wait_drained();
        end

        no_gaps = 1'b0;
        repeat (200) @(posedge aclk);
        if (n_fail == 0 && n_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
